FILE: design/boundary_stencil_apply_assert.svh
// assertion macros used by the checker file
`ifndef BOUNDARY_STENCIL_APPLY_ASSERT_SVH
`define BOUNDARY_STENCIL_APPLY_ASSERT_SVH

// property checked only out of reset
`define BSA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/bsa_pkg.sv
package bsa_pkg;

	localparam int FIELD_DEPTH_DEF = 4096;
	localparam int BODY_DEPTH_DEF  = 256;
	localparam int MAX_POINTS_DEF  = 6;

	localparam logic [2:0] REQ_WR_FIELD = 3'd0;
	localparam logic [2:0] REQ_RD_FIELD = 3'd1;
	localparam logic [2:0] REQ_WR_BODY  = 3'd2;
	localparam logic [2:0] REQ_POINT    = 3'd3;
	localparam logic [2:0] REQ_CLOSE    = 3'd4;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_WRITTEN = 3'd1;
	localparam logic [2:0] STAT_SKIPPED = 3'd2;
	localparam logic [2:0] STAT_EXTRA   = 3'd3;
	localparam logic [2:0] STAT_SAT     = 3'd4;

	localparam logic [1:0] KIND_FIXED = 2'd0;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [11:0]        index;
		logic [7:0]         body;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic [1:0]         bc_flag;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [2:0]         status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DONE
	} seq_state_t;

endpackage

FILE: design/boundary_stencil_apply.sv
// a result is registered at the output when its item finishes; the sequencer
// works on one item at a time through the memory read, multiply, sum and
// write-back steps, holding in the done state while an earlier result is not taken
// a new item is taken while the previous result still waits at the output
// reset clears the sequencer, accumulator, point count, coefficient select and
// output valid; field and boundary memories are undefined until written
module boundary_stencil_apply #(
	parameter int FIELD_DEPTH = bsa_pkg::FIELD_DEPTH_DEF,
	parameter int BODY_DEPTH  = bsa_pkg::BODY_DEPTH_DEF,
	parameter int MAX_POINTS  = bsa_pkg::MAX_POINTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bsa_pkg::req_item_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bsa_pkg::rsp_item_t rsp,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	localparam int FAW = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
	localparam int BAW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
	localparam int FXW = (FAW > 12) ? FAW : 12;
	localparam int BXW = (BAW > 8) ? BAW : 8;

	logic [31:0] field_mem [FIELD_DEPTH];
	logic [31:0] bval_mem [BODY_DEPTH];
	logic [1:0]  bkind_mem [BODY_DEPTH];

	bsa_pkg::seq_state_t state_q, state_d;
	bsa_pkg::req_item_t  item_q;
	bsa_pkg::rsp_item_t  rsp_q, rsp_d;
	logic                rsp_valid_q;
	logic                coef_set_q;
	logic signed [31:0]  acc_q, acc_d;
	logic [2:0]          pcnt_q, pcnt_d;
	logic [31:0]         field_rd_q, bval_rd_q;
	logic [1:0]          bkind_rd_q;
	logic signed [63:0]  prod_q;
	logic signed [31:0]  term_q;
	logic                msat_q;

	logic                accept, finish;
	logic [FXW-1:0]      in_fidx, q_fidx;
	logic [BXW-1:0]      in_bidx, q_bidx;
	logic [FAW-1:0]      in_faddr, q_faddr;
	logic [BAW-1:0]      in_baddr, q_baddr;
	logic                fok, bok;
	logic signed [31:0]  coef, mul_b;
	logic signed [63:0]  shifted;
	logic signed [32:0]  sum;
	logic signed [31:0]  sum_sat;
	logic                asat;
	logic                fwr_en, bwr_en;
	logic [31:0]         fwr_data;

	assign accept = req_valid && req_ready;
	assign req_ready = (state_q == bsa_pkg::ST_IDLE);
	assign finish = (state_q == bsa_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready);

	assign in_fidx  = FXW'(req.index);
	assign in_bidx  = BXW'(req.body);
	assign q_fidx   = FXW'(item_q.index);
	assign q_bidx   = BXW'(item_q.body);
	assign in_faddr = in_fidx[FAW-1:0];
	assign in_baddr = in_bidx[BAW-1:0];
	assign q_faddr  = q_fidx[FAW-1:0];
	assign q_baddr  = q_bidx[BAW-1:0];
	assign fok = 32'(item_q.index) < 32'(FIELD_DEPTH);
	assign bok = 32'(item_q.body) < 32'(BODY_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_set_q <= 1'b0;
		end else if (cfg_we) begin
			coef_set_q <= cfg_wdata;
		end
	end

	// memories: read when the item is taken, written back when it finishes
	always_ff @(posedge clk) begin
		if (fwr_en) begin
			field_mem[q_faddr] <= fwr_data;
		end
		if (accept) begin
			field_rd_q <= field_mem[in_faddr];
		end
	end

	always_ff @(posedge clk) begin
		if (bwr_en) begin
			bval_mem[q_baddr]  <= item_q.value_a;
			bkind_mem[q_baddr] <= item_q.bc_flag;
		end
		if (accept) begin
			bval_rd_q  <= bval_mem[in_baddr];
			bkind_rd_q <= bkind_mem[in_baddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
	end

	assign coef  = coef_set_q ? item_q.value_b : item_q.value_a;
	assign mul_b = (item_q.req_type == bsa_pkg::REQ_CLOSE) ? $signed(bval_rd_q)
		: $signed(field_rd_q);

	always_ff @(posedge clk) begin
		if (state_q == bsa_pkg::ST_READ) begin
			prod_q <= coef * mul_b;
		end
	end

	// arithmetic shift floors, matching the rounding toward minus infinity
	assign shifted = prod_q >>> 16;

	always_ff @(posedge clk) begin
		if (state_q == bsa_pkg::ST_MUL) begin
			if (shifted[63:31] != {33{shifted[63]}}) begin
				msat_q <= 1'b1;
				term_q <= shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
			end else begin
				msat_q <= 1'b0;
				term_q <= shifted[31:0];
			end
		end
	end

	assign sum     = 33'(acc_q) + 33'(term_q);
	assign asat    = sum[32] != sum[31];
	assign sum_sat = asat ? (sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];

	always_comb begin
		state_d  = state_q;
		acc_d    = acc_q;
		pcnt_d   = pcnt_q;
		rsp_d    = '0;
		fwr_en   = 1'b0;
		bwr_en   = 1'b0;
		fwr_data = item_q.value_a;
		unique case (state_q)
			bsa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = bsa_pkg::ST_READ;
				end
			end
			bsa_pkg::ST_READ: state_d = bsa_pkg::ST_MUL;
			bsa_pkg::ST_MUL:  state_d = bsa_pkg::ST_DONE;
			bsa_pkg::ST_DONE: begin
				if (finish) begin
					state_d = bsa_pkg::ST_IDLE;
					unique case (item_q.req_type)
						bsa_pkg::REQ_WR_FIELD: fwr_en = fok;
						bsa_pkg::REQ_RD_FIELD: begin
							if (fok) begin
								rsp_d.read_data = field_rd_q;
							end
						end
						bsa_pkg::REQ_WR_BODY: bwr_en = bok;
						bsa_pkg::REQ_POINT: begin
							if (pcnt_q >= 3'(MAX_POINTS)) begin
								rsp_d.status = bsa_pkg::STAT_EXTRA;
							end else begin
								pcnt_d = pcnt_q + 3'd1;
								if (fok) begin
									acc_d = sum_sat;
									if (msat_q || asat) begin
										rsp_d.status = bsa_pkg::STAT_SAT;
									end
								end
							end
						end
						bsa_pkg::REQ_CLOSE: begin
							acc_d  = '0;
							pcnt_d = '0;
							if (fok && bok && bkind_rd_q == bsa_pkg::KIND_FIXED) begin
								fwr_en          = 1'b1;
								fwr_data        = sum_sat;
								rsp_d.read_data = sum_sat;
								rsp_d.status    = (msat_q || asat) ? bsa_pkg::STAT_SAT
									: bsa_pkg::STAT_WRITTEN;
							end else begin
								rsp_d.status = bsa_pkg::STAT_SKIPPED;
							end
						end
						default: ;
					endcase
				end
			end
			default: state_d = bsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsa_pkg::ST_IDLE;
			acc_q       <= '0;
			pcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			pcnt_q  <= pcnt_d;
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: design/bsa_checker.sv
`include "boundary_stencil_apply_assert.svh"

module bsa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input bsa_pkg::rsp_item_t rsp
);

	`BSA_ASSERT_ALWAYS(a_rst_no_rsp, clk, !arst_n |-> !rsp_valid, "result valid during reset")

	`BSA_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled result changed")

	// one item in flight: the block is busy after taking one
	`BSA_ASSERT(a_busy, clk, arst_n, req_valid && req_ready |=> !req_ready, "item taken while busy")

	// taking an item while no result waits leaves the result valid low: a result comes only when the item finishes
	`BSA_ASSERT(a_no_early, clk, arst_n, req_valid && req_ready && !rsp_valid |=> !rsp_valid, "result too early")

	`BSA_ASSERT(a_zero_data, clk, arst_n, rsp_valid && (rsp.status == bsa_pkg::STAT_SKIPPED || rsp.status == bsa_pkg::STAT_EXTRA) |-> rsp.read_data == 0, "data on skipped item")

endmodule

bind boundary_stencil_apply bsa_checker u_bsa_checker (.*);
